[hw/rtl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_item;

    typedef logic [7:0][31:0] t_digest;

    localparam logic [7:0]  PAD_MARK  = 8'h80;
    localparam logic [5:0]  LEN_START = 6'd56;

    localparam t_digest INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[hw/rtl/sha_front.sv]
// ----------------------------------------------------------------------------
// sha_front
// Input queue: take items, drop those with neither byte nor end flag.
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    t_item       r_mem [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic        n_store;
    logic        n_take;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];

    // keep only items that change state
    assign n_store = i_push && !o_full &&
                     (i_item.byte_present || i_item.end_of_message);
    assign n_take  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (n_store) begin
            r_mem[r_wr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_store) begin
                r_wr <= ~r_wr;
            end
            if (n_take) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(n_store) - 2'(n_take);
        end
    end

endmodule

[hw/rtl/sha_core.sv]
// ----------------------------------------------------------------------------
// sha_core
// Byte absorption, padding sequencer and one-round-per-cycle compression.
// ----------------------------------------------------------------------------
module sha_core
    import sha_pkg::*;
#(
    parameter int unsigned LENGTH_COUNTER_WIDTH = 61
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_take,
    input  logic    i_out_free,
    output logic    o_load,
    output t_digest o_digest
);

    typedef enum logic [7:0] {
        S_ABSORB = 8'b0000_0001,
        S_PAD80  = 8'b0000_0010,
        S_PADZ   = 8'b0000_0100,
        S_PADLEN = 8'b0000_1000,
        S_LOAD   = 8'b0001_0000,
        S_ROUND  = 8'b0010_0000,
        S_ADD    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state                          r_state, n_state;
    t_state                          r_ret, n_ret;
    logic [5:0]                      r_pos;
    logic [LENGTH_COUNTER_WIDTH-1:0] r_cnt;
    logic [511:0]                    r_buf;
    logic [31:0]                     r_win [16];
    logic [31:0]                     r_v [8];
    t_digest                         r_h;
    logic [5:0]                      r_rnd;

    logic        n_shift;
    logic [7:0]  n_byte;
    logic [63:0] n_bits;
    logic [31:0] n_t1, n_t2, n_wnew;

    assign o_take   = (r_state == S_ABSORB);
    assign o_load   = (r_state == S_DONE) && i_out_free;
    assign o_digest = r_h;
    assign n_bits   = 64'(r_cnt) << 3;

    assign n_t1 = r_v[7] + big_sig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + ROUND_K[r_rnd] + r_win[0];
    assign n_t2 = big_sig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2])
                ^ (r_v[1] & r_v[2]));
    assign n_wnew = small_sig1(r_win[14]) + r_win[9] + small_sig0(r_win[1]) + r_win[0];

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_shift = 1'b0;
        n_byte  = 8'h00;
        unique case (r_state)
            S_ABSORB: begin
                if (i_valid) begin
                    if (i_item.byte_present) begin
                        n_shift = 1'b1;
                        n_byte  = i_item.data_byte;
                        if (r_pos == 6'd63) begin
                            n_state = S_LOAD;
                            n_ret   = i_item.end_of_message ? S_PAD80 : S_ABSORB;
                        end else if (i_item.end_of_message) begin
                            n_state = S_PAD80;
                        end
                    end else begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_PAD80: begin
                n_shift = 1'b1;
                n_byte  = PAD_MARK;
                n_state = S_PADZ;
                if (r_pos == 6'd63) begin
                    n_state = S_LOAD;
                    n_ret   = S_PADZ;
                end
            end
            S_PADZ: begin
                if (r_pos == LEN_START) begin
                    n_state = S_PADLEN;
                end else begin
                    n_shift = 1'b1;
                    if (r_pos == 6'd63) begin
                        n_state = S_LOAD;
                        n_ret   = S_PADZ;
                    end
                end
            end
            S_PADLEN: begin
                n_shift = 1'b1;
                n_byte  = n_bits[{~r_pos[2:0], 3'b000} +: 8];
                if (r_pos == 6'd63) begin
                    n_state = S_LOAD;
                    n_ret   = S_DONE;
                end
            end
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: n_state = (r_rnd == 6'd63) ? S_ADD : S_ROUND;
            S_ADD:   n_state = r_ret;
            S_DONE:  n_state = i_out_free ? S_ABSORB : S_DONE;
            default: n_state = S_ABSORB;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_shift) begin
            r_buf <= {r_buf[503:0], n_byte};
        end
        if (r_state == S_LOAD) begin
            for (int j = 0; j < 16; j++) begin
                r_win[j] <= r_buf[511 - 32*j -: 32];
            end
            for (int j = 0; j < 8; j++) begin
                r_v[j] <= r_h[j];
            end
        end
        if (r_state == S_ROUND) begin
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[15] <= n_wnew;
            for (int j = 1; j < 8; j++) begin
                r_v[j] <= r_v[j-1];
            end
            r_v[4] <= r_v[3] + n_t1;
            r_v[0] <= n_t1 + n_t2;
        end
        if (!i_rst_n) begin
            r_state <= S_ABSORB;
            r_ret   <= S_ABSORB;
            r_pos   <= 6'd0;
            r_cnt   <= '0;
            r_rnd   <= 6'd0;
            r_h     <= INIT_H;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (n_shift) begin
                r_pos <= r_pos + 6'd1;
            end
            if (r_state == S_ABSORB && i_valid && i_item.byte_present) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_LOAD) begin
                r_rnd <= 6'd0;
            end else if (r_state == S_ROUND) begin
                r_rnd <= r_rnd + 6'd1;
            end
            if (r_state == S_ADD) begin
                for (int j = 0; j < 8; j++) begin
                    r_h[j] <= r_h[j] + r_v[j];
                end
            end
            if (o_load) begin
                r_h   <= INIT_H;
                r_cnt <= '0;
                r_pos <= 6'd0;
            end
        end
    end

endmodule

[hw/rtl/sha_out.sv]
// ----------------------------------------------------------------------------
// sha_out
// Digest hold register: shift out eight words, word 0 first.
// ----------------------------------------------------------------------------
module sha_out
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_digest     i_digest,
    output logic        o_free,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_word,
    output logic [2:0]  o_index,
    output logic        o_last
);

    t_digest    r_words;
    logic [2:0] r_idx;
    logic       r_busy;

    assign o_free  = !r_busy;
    assign o_empty = !r_busy;
    assign o_word  = r_words[0];
    assign o_index = r_idx;
    assign o_last  = (r_idx == 3'd7);

    always_ff @(posedge i_clk) begin
        if (i_load && !r_busy) begin
            r_words <= i_digest;
        end else if (i_pop && r_busy) begin
            r_words <= {32'h0, r_words[7:1]};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (i_load && !r_busy) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (i_pop && r_busy) begin
            r_idx <= r_idx + 3'd1;
            if (r_idx == 3'd7) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

[hw/rtl/sha256_message_digest_top.sv]
// ----------------------------------------------------------------------------
// sha256_message_digest_top
// SHA-256 over a byte stream, eight digest words out per message.
// ----------------------------------------------------------------------------
// Push one message byte per word; raise end_of_message on the final word
// (with byte_present low for an end marker without a byte, so an empty
// message works). A two-entry input queue takes one word per cycle while
// not full; the core absorbs one byte per cycle while a word waits, and
// stalls the queue at each full 64-byte block for its compression (load,
// 64 rounds of the single round unit, chaining add). After the end word,
// padding is shifted in one byte per cycle outside the compressions, with
// one compression when the tail leaves room for the length and two when it
// spills into a second block. The digest then moves, once it is free, into
// an output register that drains through pop while the next message is
// absorbed. Words with neither a byte nor the end flag are dropped. The
// length counter wraps modulo 2^LENGTH_COUNTER_WIDTH.
// ----------------------------------------------------------------------------
module sha256_message_digest_top
    import sha_pkg::*;
#(
    parameter int unsigned LENGTH_COUNTER_WIDTH = 61
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_item   w_in_item, w_q_item;
    logic    w_q_valid, w_take, w_free, w_load;
    t_digest w_digest;

    // pack the input word
    assign w_in_item = '{data_byte: i_data_byte, byte_present: i_byte_present,
                         end_of_message: i_end_of_message};

    sha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (w_in_item),
        .o_full  (full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_take  (w_take)
    );

    sha_core #(
        .LENGTH_COUNTER_WIDTH (LENGTH_COUNTER_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .i_item     (w_q_item),
        .o_take     (w_take),
        .i_out_free (w_free),
        .o_load     (w_load),
        .o_digest   (w_digest)
    );

    sha_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_digest (w_digest),
        .o_free   (w_free),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_word   (o_digest_word),
        .o_index  (o_word_index),
        .o_last   (o_last_word)
    );

`ifndef NO_ASSERTIONS
    // drain the last word: the result side must go empty next
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last_word) |=> empty)
        else $error("result side still holds a word after the last one");

    // hold the digest: no load while words are still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load |-> empty))
        else $error("digest loaded over undrained words");

    // advance the index only on a pop
    a_index_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_word_index)))
        else $error("word index moved without a pop");
`endif

endmodule

[test/tb_sha256_message_digest_top.sv]
// ----------------------------------------------------------------------------
// tb_sha256_message_digest_top
// Self-checking testbench for the byte-serial SHA-256 digest block.
// ----------------------------------------------------------------------------
// Messages go in one byte per word through the push/full queue. Digest words
// come out through the empty/pop queue. A scoreboard class predicts every
// digest word. Both sides idle at random, and the receiver holds off once
// for a long stretch. The length counter is built at a reduced width.
// ----------------------------------------------------------------------------
module tb_sha256_message_digest_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    // Reduced length counter width
    localparam int unsigned CNT_W      = 16;
    localparam int          IDLE_LIMIT = 20000;
    localparam int          HOLD_LEN   = 3000;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // ------------------------------------------------------------------------
    // Digest scoreboard: own SHA-256 state, queue of pending digest words
    // ------------------------------------------------------------------------
    class digest_scoreboard;
        logic [7:0]    blk [64];
        logic [63:0]   nbytes;
        logic [31:0]   hv [8];
        t_digest_word  pending [$];
        int            mismatches;
        int            words_seen;
        int            messages;

        function new();
            mismatches = 0;
            words_seen = 0;
            messages   = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) hv[i] = INIT_H[i];
            nbytes = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] wt, t1, t2, x15, x2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 0; i < 8; i++) v[i] = hv[i];
            for (int i = 0; i < 64; i++) begin
                if (i < 16) begin
                    wt = w[i];
                end else begin
                    x15 = w[(i + 1) & 15];
                    x2  = w[(i + 14) & 15];
                    wt  = w[i & 15] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3))
                        + w[(i + 9) & 15] + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
                    w[i & 15] = wt;
                end
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + wt;
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                for (int j = 7; j > 0; j--) v[j] = v[j-1];
                v[4] = v[4] + t1;
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
        endfunction

        // Absorb one accepted word; on an end word, pad and queue the digest
        function void note_word(logic [7:0] data, logic present, logic eom);
            int          pos;
            logic [63:0] bits;
            t_digest_word d;
            if (present) begin
                blk[nbytes[5:0]] = data;
                nbytes = (nbytes + 1) & ((64'd1 << CNT_W) - 1);
                if (nbytes[5:0] == 0) compress();
            end
            if (!eom) return;
            pos = nbytes[5:0];
            blk[pos] = PAD_MARK;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin blk[pos] = 8'h00; pos++; end
                compress();
                pos = 0;
            end
            while (pos < 56) begin blk[pos] = 8'h00; pos++; end
            bits = nbytes << 3;
            for (int i = 0; i < 8; i++) blk[56+i] = bits[63 - 8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                d.word  = hv[i];
                d.index = 3'(i);
                d.last  = (i == 7);
                pending = {pending, d};
            end
            messages++;
            restart();
        endfunction

        function void check_word(logic [31:0] word, logic [2:0] index, logic last);
            t_digest_word d;
            words_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected digest word %h idx %0d last %0b",
                             word, index, last);
                return;
            end
            d = pending.pop_front();
            if (word !== d.word || index !== d.index || last !== d.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: word %h/%h idx %0d/%0d last %0b/%0b (exp/act)",
                             d.word, word, d.index, index, d.last, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_scoreboard sb = new();
    bit  hold_req = 0;
    bit  no_idle  = 0;
    int  idle_cycles = 0;
    int  bytes_sent  = 0;

    sha256_message_digest_top #(
        .LENGTH_COUNTER_WIDTH(CNT_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_end_of_message(i_end_of_message),
        .empty           (empty),
        .pop             (pop),
        .o_digest_word   (o_digest_word),
        .o_word_index    (o_word_index),
        .o_last_word     (o_last_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones; none while no_idle is set
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(logic [7:0] data, logic present, logic eom);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_data_byte      <= data;
        i_byte_present   <= present;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (full);
        sb.note_word(data, present, eom);
        if (present) bytes_sent++;
    endtask

    // Random message content, ending either with a byte or with a bare marker
    task automatic send_message(int len);
        bit end_on_byte;
        end_on_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
            // Drop in the odd word that carries nothing
            if ($urandom_range(0, 39) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver: check each popped word, then decide the next pop
    always @(posedge i_clk) begin : receiver
        int hold_left;
        int gap_left;
        if (pop && !empty) sb.check_word(o_digest_word, o_word_index, o_last_word);
        if (hold_req) begin
            hold_req  = 0;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else if (gap_left > 0) begin
            pop <= 1'b0;
            gap_left--;
        end else begin
            pop <= 1'b1;
            if (pop && !empty) gap_left = pick_gap();
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int r;
        int len;
        int random_bytes;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message straight after reset
        send_word(8'h00, 1'b0, 1'b1);
        // Nothing word followed by a bare end marker
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h5a, 1'b0, 1'b1);
        // Single byte carried on the end word, both byte extremes
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        // "abc" closed by a bare marker
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // Padding boundary: 56 bytes forces a second block
        for (int i = 0; i < 55; i++) send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);

        // Stall the receiver for a long stretch while messages keep coming
        hold_req = 1;
        for (int m = 0; m < 4; m++) send_message($urandom_range(0, 12));

        // Random messages: mostly short, some around block boundaries
        random_bytes = 0;
        while (random_bytes < 400) begin
            r = $urandom_range(0, 99);
            no_idle = ($urandom_range(0, 4) == 0);
            if (r < 55)      len = $urandom_range(0, 20);
            else if (r < 85) len = $urandom_range(52, 72);
            else             len = $urandom_range(100, 200);
            send_message(len);
            random_bytes += len + 1;
        end

        no_idle = 0;
        send_message(5);

        push <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d messages, %0d bytes, %0d digest words checked",
                 sb.messages, bytes_sent, sb.words_seen);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sha_pkg.sv
hw/rtl/sha_front.sv
hw/rtl/sha_core.sv
hw/rtl/sha_out.sv
hw/rtl/sha256_message_digest_top.sv
test/tb_sha256_message_digest_top.sv
